// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds on every clock edge out of reset.
`define STOK_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define STOK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define STOK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STOK_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define STOK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define STOK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/stok_pkg.sv =====
package stok_pkg;

    localparam int BYTE_W      = 8;
    localparam int TOKEN_LEN_W = 10;
    localparam int LINE_W      = 24;
    localparam int SLOT_N      = 3;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] SPACE_MAX  = 8'd32;

    localparam logic [LINE_W-1:0] LINE_ONE = 24'd1;
    localparam logic [LINE_W-1:0] LINE_MAX = 24'hFFFFFF;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_EOS   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] ERR_LINE  = 2'd0;
    localparam logic [1:0] ERR_QUOTE = 2'd1;
    localparam logic [1:0] ERR_LONG  = 2'd2;

    typedef enum logic [2:0] {
        MODE_SPACE   = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_BARE    = 3'd3,
        MODE_QUOTED  = 3'd4,
        MODE_ERROR   = 3'd5
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              allow_crossline;
    } stok_in_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [BYTE_W-1:0]      token_byte;
        logic [TOKEN_LEN_W-1:0] token_length;
        logic [1:0]             error_code;
        logic [LINE_W-1:0]      line_number;
        logic                   last;
    } stok_out_t;

    // One result slot, without the fields shared by the whole bundle.
    typedef struct packed {
        logic [1:0]             kind;
        logic [BYTE_W-1:0]      token_byte;
        logic [TOKEN_LEN_W-1:0] token_length;
        logic [1:0]             error_code;
    } rslt_t;

    // All results caused by one input beat.
    typedef struct packed {
        logic [1:0]              cnt;
        logic [LINE_W-1:0]       line_number;
        rslt_t [SLOT_N-1:0]      slots;
    } bundle_t;

    function automatic rslt_t mk_byte(input logic [BYTE_W-1:0] b);
        rslt_t r;
        r = '0;
        r.kind       = KIND_BYTE;
        r.token_byte = b;
        return r;
    endfunction

    function automatic rslt_t mk_end(input logic [TOKEN_LEN_W-1:0] len);
        rslt_t r;
        r = '0;
        r.kind         = KIND_END;
        r.token_length = len;
        return r;
    endfunction

    function automatic rslt_t mk_err(input logic [1:0] code);
        rslt_t r;
        r = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic rslt_t mk_eos();
        rslt_t r;
        r = '0;
        r.kind = KIND_EOS;
        return r;
    endfunction

endpackage

// ===== src/script_tokenizer.sv =====
// Script tokenizer: splits a stream of script bytes into tokens.
// Input channel s_valid/s_ready/s_data carries one script byte per beat plus
// allow_crossline. Output channel m_valid/m_ready/m_data carries result beats:
// token bytes, token ends with length, end of script, or errors; the final
// beat caused by an input byte has last set. One input byte yields 0 to 3
// result beats.
// Path: a byte lands in the input register, is decoded combinationally
// against the scan state, and its results are loaded into the result
// register that drives m_data.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver is ready; a byte with several results holds the next byte
// while the single output port drains the result register one beat per cycle.
// Bytes with no result (spaces, comments) pass at one per cycle regardless.
// Reset (aresetn low, synchronous) empties both registers, puts the scanner
// in space-skipping mode with line count 1. When the receiver stalls, the
// result register holds; one more byte waits in the input register and then
// s_ready drops, so no beat is lost.
`include "assert_macros.svh"

module script_tokenizer
    import stok_pkg::*;
#(
    parameter int MAX_TOKEN = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  stok_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output stok_out_t m_data
);

    localparam int LEN_W = $clog2(MAX_TOKEN + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN);

    // Input register.
    logic              in_valid_reg;
    stok_in_t          in_beat_reg;

    // Scan state.
    mode_t             mode_reg;
    mode_t             mode_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;

    bundle_t           bundle;
    logic              can_load;
    logic              adv;

    // Advance the held byte when its results fit in the result register;
    // a byte with no results never waits on the output side.
    assign adv     = in_valid_reg && ((bundle.cnt == 2'd0) || can_load);
    assign s_ready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SPACE;
            line_reg <= LINE_ONE;
            len_reg  <= '0;
        end else if (adv) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            len_reg  <= len_next;
        end
    end

    stok_step #(
        .MAX_TOKEN (MAX_TOKEN),
        .LEN_W     (LEN_W)
    ) u_step (
        .mode      (mode_reg),
        .line      (line_reg),
        .len       (len_reg),
        .beat      (in_beat_reg),
        .mode_next (mode_next),
        .line_next (line_next),
        .len_next  (len_next),
        .bundle    (bundle)
    );

    stok_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (adv && (bundle.cnt != 2'd0)),
        .bundle   (bundle),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Line count never drops to zero.
    `STOK_ASSERT_ALWAYS(a_line_nonzero, aclk, aresetn, line_reg != '0,
        "line count is zero")

    // Byte 0 always rewinds the line count, whatever mode it hits.
    `STOK_ASSERT_NEXT(a_nul_rewinds, aclk, aresetn,
        adv && (in_beat_reg.data_byte == CHAR_NUL), line_reg == LINE_ONE,
        "byte 0 did not reset line count")

    // Inside a token the length stays below the limit.
    `STOK_ASSERT_IMP(a_len_bound, aclk, aresetn,
        (mode_reg == MODE_BARE) || (mode_reg == MODE_QUOTED), len_reg < MAX_LEN,
        "token length over limit")

endmodule

// ===== src/stok_step.sv =====
module stok_step
    import stok_pkg::*;
#(
    parameter int MAX_TOKEN = 1024,
    parameter int LEN_W     = $clog2(MAX_TOKEN + 1)
) (
    input  mode_t             mode,
    input  logic [LINE_W-1:0] line,
    input  logic [LEN_W-1:0]  len,
    input  stok_in_t          beat,
    output mode_t             mode_next,
    output logic [LINE_W-1:0] line_next,
    output logic [LEN_W-1:0]  len_next,
    output bundle_t           bundle
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN);
    localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);
    localparam logic [LEN_W-1:0] TWO_LEN = LEN_W'(2);

    logic [BYTE_W-1:0] b;
    logic              xline;
    logic [LINE_W-1:0] line_inc;
    logic [LEN_W-1:0]  len_inc;
    logic              cur_fail;
    logic              one_fail;
    logic              two_fail;

    // Separator handling, shared by several modes.
    logic              sp_emit;
    rslt_t             sp_rslt;
    mode_t             sp_mode;
    logic [LINE_W-1:0] sp_line;
    logic [LEN_W-1:0]  sp_len;

    assign b        = beat.data_byte;
    assign xline    = beat.allow_crossline;
    assign line_inc = (line != LINE_MAX) ? line + LINE_ONE : line;
    assign len_inc  = len + ONE_LEN;
    assign cur_fail = (len_inc >= MAX_LEN);
    assign one_fail = (ONE_LEN >= MAX_LEN);
    assign two_fail = (TWO_LEN >= MAX_LEN);

    always_comb begin
        sp_emit = 1'b0;
        sp_rslt = '0;
        sp_mode = MODE_SPACE;
        sp_line = line;
        sp_len  = len;
        if (b == CHAR_NUL) begin
            sp_emit = 1'b1;
            sp_line = LINE_ONE;
            sp_rslt = xline ? mk_eos() : mk_err(ERR_LINE);
        end else if (b == CHAR_NL) begin
            if (!xline) begin
                sp_emit = 1'b1;
                sp_rslt = mk_err(ERR_LINE);
                sp_mode = MODE_ERROR;
            end else begin
                sp_line = line_inc;
            end
        end else if (b <= SPACE_MAX) begin
            sp_mode = MODE_SPACE;
        end else if (b == CHAR_SLASH) begin
            sp_mode = MODE_SLASH;
        end else if (b == CHAR_QUOTE) begin
            sp_mode = MODE_QUOTED;
            sp_len  = '0;
        end else begin
            sp_emit = 1'b1;
            sp_len  = ONE_LEN;
            if (one_fail) begin
                sp_rslt = mk_err(ERR_LONG);
                sp_mode = MODE_ERROR;
            end else begin
                sp_rslt = mk_byte(b);
                sp_mode = MODE_BARE;
            end
        end
    end

    always_comb begin
        mode_next          = mode;
        line_next          = line;
        len_next           = len;
        bundle             = '0;
        bundle.line_number = line;
        case (mode)
            MODE_SLASH: begin
                if (b == CHAR_SLASH) begin
                    if (!xline) begin
                        bundle.slots[0] = mk_err(ERR_LINE);
                        bundle.cnt      = 2'd1;
                        mode_next       = MODE_ERROR;
                    end else begin
                        mode_next = MODE_COMMENT;
                    end
                end else if (one_fail) begin
                    bundle.slots[0] = mk_err(ERR_LONG);
                    bundle.cnt      = 2'd1;
                    mode_next       = MODE_ERROR;
                    len_next        = ONE_LEN;
                end else begin
                    // Release the held slash as the first token byte.
                    bundle.slots[0] = mk_byte(CHAR_SLASH);
                    len_next        = ONE_LEN;
                    if (b > SPACE_MAX) begin
                        len_next   = TWO_LEN;
                        bundle.cnt = 2'd2;
                        if (two_fail) begin
                            bundle.slots[1] = mk_err(ERR_LONG);
                            mode_next       = MODE_ERROR;
                        end else begin
                            bundle.slots[1] = mk_byte(b);
                            mode_next       = MODE_BARE;
                        end
                    end else begin
                        bundle.slots[1] = mk_end(TOKEN_LEN_W'(ONE_LEN));
                        bundle.slots[2] = sp_rslt;
                        bundle.cnt      = sp_emit ? 2'd3 : 2'd2;
                        mode_next       = sp_mode;
                        line_next       = sp_line;
                    end
                end
            end
            MODE_COMMENT: begin
                if (b == CHAR_NUL) begin
                    bundle.slots[0] = sp_rslt;
                    bundle.cnt      = {1'b0, sp_emit};
                    mode_next       = sp_mode;
                    line_next       = sp_line;
                end else if (b == CHAR_NL) begin
                    line_next = line_inc;
                    mode_next = MODE_SPACE;
                end else begin
                    mode_next = MODE_COMMENT;
                end
            end
            MODE_BARE: begin
                if (b > SPACE_MAX) begin
                    len_next   = len_inc;
                    bundle.cnt = 2'd1;
                    if (cur_fail) begin
                        bundle.slots[0] = mk_err(ERR_LONG);
                        mode_next       = MODE_ERROR;
                    end else begin
                        bundle.slots[0] = mk_byte(b);
                    end
                end else begin
                    bundle.slots[0] = mk_end(TOKEN_LEN_W'(len));
                    bundle.slots[1] = sp_rslt;
                    bundle.cnt      = sp_emit ? 2'd2 : 2'd1;
                    mode_next       = sp_mode;
                    line_next       = sp_line;
                end
            end
            MODE_QUOTED: begin
                bundle.cnt = 2'd1;
                if (b == CHAR_QUOTE) begin
                    bundle.slots[0] = mk_end(TOKEN_LEN_W'(len));
                    mode_next       = MODE_SPACE;
                end else if (b == CHAR_NUL) begin
                    bundle.slots[0] = mk_err(ERR_QUOTE);
                    mode_next       = MODE_SPACE;
                    line_next       = LINE_ONE;
                end else begin
                    len_next = len_inc;
                    if (cur_fail) begin
                        bundle.slots[0] = mk_err(ERR_LONG);
                        mode_next       = MODE_ERROR;
                    end else begin
                        bundle.slots[0] = mk_byte(b);
                    end
                end
            end
            MODE_ERROR: begin
                if (b == CHAR_NUL) begin
                    bundle.slots[0] = mk_eos();
                    bundle.cnt      = 2'd1;
                    mode_next       = MODE_SPACE;
                    line_next       = LINE_ONE;
                end
            end
            default: begin
                bundle.slots[0] = sp_rslt;
                bundle.cnt      = {1'b0, sp_emit};
                mode_next       = sp_mode;
                line_next       = sp_line;
                len_next        = sp_len;
            end
        endcase
    end

endmodule

// ===== src/stok_out.sv =====
module stok_out
    import stok_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  bundle_t   bundle,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output stok_out_t m_data
);

    bundle_t    bnd_reg;
    logic       bnd_valid_reg;
    logic [1:0] idx_reg;
    logic       is_last;
    rslt_t      slot;

    assign is_last  = (idx_reg == bnd_reg.cnt - 2'd1);
    assign can_load = !bnd_valid_reg || (m_ready && is_last);
    assign m_valid  = bnd_valid_reg;
    assign slot     = bnd_reg.slots[idx_reg];

    always_comb begin
        m_data.kind         = slot.kind;
        m_data.token_byte   = slot.token_byte;
        m_data.token_length = slot.token_length;
        m_data.error_code   = slot.error_code;
        m_data.line_number  = bnd_reg.line_number;
        m_data.last         = is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bnd_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (load) begin
            bnd_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end else if (bnd_valid_reg && m_ready) begin
            if (is_last) begin
                bnd_valid_reg <= 1'b0;
                idx_reg       <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bnd_reg <= bundle;
        end
    end

endmodule

// ===== bench/script_tokenizer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, predicts the result beats of each
// accepted script byte and compares them in order with what comes out.
module script_tokenizer_checker
    import stok_pkg::*;
#(
    parameter int MAX_TOKEN = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  stok_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  stok_out_t m_data,
    input  logic      run_done,
    output int        fault_count,
    output int        beats_due
);

    mode_t             scan_st;
    logic [LINE_W-1:0] line_no;
    int                tok_len;
    stok_out_t         step_beats[$];
    stok_out_t         due_beats[$];
    int                beat_idx = 0;
    int                fault_total = 0;
    int                due_n = 0;
    bit                leftovers_seen = 1'b0;

    assign fault_count = fault_total;
    assign beats_due   = due_n;

    task automatic flag_mismatch(input string what);
        fault_total++;
        $display("[%0t] tokenizer mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [LINE_W-1:0] got,
                               input logic [LINE_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                    beat_idx, name, got, want));
    endtask

    function automatic void post(input logic [1:0] k, input logic [BYTE_W-1:0] b,
                                 input logic [TOKEN_LEN_W-1:0] n, input logic [1:0] code);
        stok_out_t r;
        r              = '0;
        r.kind         = k;
        r.token_byte   = b;
        r.token_length = n;
        r.error_code   = code;
        r.line_number  = line_no;
        step_beats.push_back(r);
    endfunction

    function automatic void abort_script(input logic [1:0] code);
        post(KIND_ERROR, '0, '0, code);
        scan_st = MODE_ERROR;
    endfunction

    // The end-of-script byte itself failed: no EOS beat, restart clean.
    function automatic void abort_at_end(input logic [1:0] code);
        post(KIND_ERROR, '0, '0, code);
        scan_st = MODE_SPACE;
        line_no = LINE_ONE;
    endfunction

    function automatic void bump_line();
        if (line_no != LINE_MAX)
            line_no++;
    endfunction

    function automatic void take_token_byte(input logic [BYTE_W-1:0] b);
        tok_len++;
        if (tok_len >= MAX_TOKEN)
            abort_script(ERR_LONG);
        else
            post(KIND_BYTE, b, '0, '0);
    endfunction

    function automatic void skip_space(input logic [BYTE_W-1:0] b, input logic xline);
        if (b == CHAR_NUL) begin
            if (!xline) begin
                abort_at_end(ERR_LINE);
            end else begin
                post(KIND_EOS, '0, '0, '0);
                line_no = LINE_ONE;
                scan_st = MODE_SPACE;
            end
        end else if (b == CHAR_NL) begin
            if (!xline)
                abort_script(ERR_LINE);
            else
                bump_line();
        end else if (b > SPACE_MAX) begin
            if (b == CHAR_SLASH) begin
                scan_st = MODE_SLASH;
            end else if (b == CHAR_QUOTE) begin
                scan_st = MODE_QUOTED;
                tok_len = 0;
            end else begin
                scan_st = MODE_BARE;
                tok_len = 0;
                take_token_byte(b);
            end
        end
    endfunction

    function automatic void extend_bare(input logic [BYTE_W-1:0] b, input logic xline);
        if (b > SPACE_MAX) begin
            take_token_byte(b);
        end else begin
            post(KIND_END, '0, tok_len[TOKEN_LEN_W-1:0], '0);
            scan_st = MODE_SPACE;
            skip_space(b, xline);
        end
    endfunction

    function automatic void scan_byte(input stok_in_t beat);
        logic [BYTE_W-1:0] b;
        logic              xline;
        stok_out_t         tail;
        b     = beat.data_byte;
        xline = beat.allow_crossline;
        step_beats.delete();
        case (scan_st)
            MODE_SLASH: begin
                if (b == CHAR_SLASH) begin
                    if (!xline)
                        abort_script(ERR_LINE);
                    else
                        scan_st = MODE_COMMENT;
                end else begin
                    scan_st = MODE_BARE;
                    tok_len = 0;
                    take_token_byte(CHAR_SLASH);
                    if (scan_st == MODE_BARE)
                        extend_bare(b, xline);
                end
            end
            MODE_COMMENT: begin
                if (b == CHAR_NUL) begin
                    skip_space(b, xline);
                end else if (b == CHAR_NL) begin
                    bump_line();
                    scan_st = MODE_SPACE;
                end
            end
            MODE_BARE: extend_bare(b, xline);
            MODE_QUOTED: begin
                if (b == CHAR_QUOTE) begin
                    post(KIND_END, '0, tok_len[TOKEN_LEN_W-1:0], '0);
                    scan_st = MODE_SPACE;
                end else if (b == CHAR_NUL) begin
                    abort_at_end(ERR_QUOTE);
                end else begin
                    take_token_byte(b);
                end
            end
            MODE_ERROR: begin
                if (b == CHAR_NUL) begin
                    post(KIND_EOS, '0, '0, '0);
                    line_no = LINE_ONE;
                    scan_st = MODE_SPACE;
                end
            end
            default: begin
                scan_st = MODE_SPACE;
                skip_space(b, xline);
            end
        endcase
        if (step_beats.size() > 0) begin
            tail      = step_beats.pop_back();
            tail.last = 1'b1;
            step_beats.push_back(tail);
        end
        foreach (step_beats[i])
            due_beats.push_back(step_beats[i]);
    endfunction

    always @(posedge aclk) begin : watch
        stok_out_t want;
        if (!aresetn) begin
            scan_st = MODE_SPACE;
            line_no = LINE_ONE;
            tok_len = 0;
            due_beats.delete();
        end else begin
            if (s_valid && s_ready)
                scan_byte(s_data);
            if (m_valid && m_ready) begin
                if (due_beats.size() == 0) begin
                    flag_mismatch($sformatf("beat %0d arrived with nothing expected", beat_idx));
                end else begin
                    want = due_beats.pop_front();
                    check_field("kind", LINE_W'(m_data.kind), LINE_W'(want.kind));
                    check_field("token_byte", LINE_W'(m_data.token_byte),
                                LINE_W'(want.token_byte));
                    check_field("token_length", LINE_W'(m_data.token_length),
                                LINE_W'(want.token_length));
                    check_field("error_code", LINE_W'(m_data.error_code),
                                LINE_W'(want.error_code));
                    check_field("line_number", m_data.line_number, want.line_number);
                    check_field("last", LINE_W'(m_data.last), LINE_W'(want.last));
                end
                beat_idx++;
            end
            if (run_done && !leftovers_seen) begin
                leftovers_seen = 1'b1;
                if (due_beats.size() != 0)
                    flag_mismatch($sformatf("%0d expected beats never arrived",
                                            due_beats.size()));
            end
        end
        due_n <= due_beats.size();
    end

endmodule

// ===== bench/script_tokenizer_tb.sv =====
`timescale 1ns / 1ps

// Top of the tokenizer bench: makes the clock, the reset, the script bytes
// and the receiver's ready pattern. Prediction and comparison live in the
// checker instance beside the block; this module only reads its counts.
module script_tokenizer_tb;
    import stok_pkg::*;

    localparam int TOK_MAX       = 1024;
    localparam int RANDOM_BEATS  = 360;
    localparam int HOLD_OFF_SPAN = 300;  // cycles the receiver refuses beats
    localparam int DRAIN_CYCLES  = 16;   // extra wait after the last predicted beat

    logic      aclk     = 1'b0;
    logic      aresetn  = 1'b0;
    logic      s_valid  = 1'b0;
    logic      s_ready;
    stok_in_t  s_data   = '0;
    logic      m_valid;
    logic      m_ready  = 1'b0;
    stok_out_t m_data;
    logic      run_done = 1'b0;
    int        fault_count;
    int        beats_due;

    // Idle odds in percent per cycle; the sender's is read only by the
    // stimulus process, the receiver's is handed over by nonblocking writes.
    int        send_idle_pct   = 0;
    int        recv_idle_pct   = 0;
    int        hold_off_asked  = 0;
    int        hold_off_served = 0;
    int        beats_sent      = 0;

    always #5 aclk = ~aclk;

    script_tokenizer #(
        .MAX_TOKEN(TOK_MAX)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    script_tokenizer_checker #(
        .MAX_TOKEN(TOK_MAX)
    ) u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .run_done   (run_done),
        .fault_count(fault_count),
        .beats_due  (beats_due)
    );

    // Offer one script byte and hold it until the block takes it. Valid drops
    // only when a gap is actually inserted, so back-to-back beats never see a
    // low and a high scheduled in the same step.
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic xline);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, allow_crossline: xline};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_text(input string txt, input logic xline);
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], xline);
    endtask

    // Draw a byte in [lo, hi] that is neither of the two barred values.
    function automatic logic [BYTE_W-1:0] pick_byte(input int lo, input int hi,
                                                    input logic [BYTE_W-1:0] bar_a,
                                                    input logic [BYTE_W-1:0] bar_b);
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(hi, lo)); while (b == bar_a || b == bar_b);
        return b;
    endfunction

    // Random scripts: mostly well-formed words, quoted strings, comments and
    // blanks with random content, plus some noise and broken lines. Every
    // script closes with a NUL so the scanner always lands back in space mode.
    task automatic run_random(input int budget);
        int stop_at;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at) begin
            repeat ($urandom_range(6, 1)) begin
                case ($urandom_range(9, 0))
                    0, 1, 2: begin
                        // bare word, terminator usually allowed to cross lines
                        send_beat(pick_byte(33, 255, CHAR_SLASH, CHAR_QUOTE),
                                  1'($urandom_range(1, 0)));
                        repeat ($urandom_range(7, 0))
                            send_beat(pick_byte(33, 255, CHAR_NUL, CHAR_NUL),
                                      1'($urandom_range(1, 0)));
                        send_beat(pick_byte(1, 32, CHAR_NUL, CHAR_NUL),
                                  $urandom_range(7, 0) != 0);
                    end
                    3, 4: begin
                        // quoted string, possibly empty, newlines allowed inside
                        send_beat(CHAR_QUOTE, 1'($urandom_range(1, 0)));
                        repeat ($urandom_range(8, 0))
                            send_beat(pick_byte(1, 255, CHAR_QUOTE, CHAR_NUL),
                                      1'($urandom_range(1, 0)));
                        send_beat(CHAR_QUOTE, 1'($urandom_range(1, 0)));
                    end
                    5: begin
                        // comment; now and then the second slash may not cross
                        send_beat(CHAR_SLASH, 1'($urandom_range(1, 0)));
                        send_beat(CHAR_SLASH, $urandom_range(7, 0) != 0);
                        repeat ($urandom_range(5, 0))
                            send_beat(pick_byte(1, 255, CHAR_NL, CHAR_NL),
                                      1'($urandom_range(1, 0)));
                        send_beat(CHAR_NL, 1'($urandom_range(1, 0)));
                    end
                    6: begin
                        repeat ($urandom_range(3, 1))
                            send_beat(pick_byte(1, 32, CHAR_NUL, CHAR_NUL),
                                      $urandom_range(7, 0) != 0);
                    end
                    7: begin
                        // raw noise, NUL included
                        repeat ($urandom_range(3, 1))
                            send_beat(BYTE_W'($urandom_range(255, 0)),
                                      1'($urandom_range(1, 0)));
                    end
                    8: begin
                        // word led by a single slash, maybe nothing after it
                        send_beat(CHAR_SLASH, 1'($urandom_range(1, 0)));
                        repeat ($urandom_range(4, 0))
                            send_beat(pick_byte(33, 255, CHAR_NUL, CHAR_NUL),
                                      1'($urandom_range(1, 0)));
                        send_beat(pick_byte(1, 32, CHAR_NUL, CHAR_NUL),
                                  $urandom_range(3, 0) != 0);
                    end
                    default: begin
                        // broken line: newline where crossing is not allowed
                        send_beat(CHAR_NL, 1'b0);
                    end
                endcase
            end
            send_beat(CHAR_NUL, $urandom_range(3, 0) != 0);
        end
    endtask

    // Receiver: random ready per cycle, except when a hold-off is asked for.
    // The hold-off is counted here so the sender keeps offering bytes and the
    // block backs up into its input.
    initial begin : receiver
        int held;
        forever begin
            @(posedge aclk);
            if (hold_off_served != hold_off_asked) begin
                m_ready <= 1'b0;
                for (held = 1; held < HOLD_OFF_SPAN; held++)
                    @(posedge aclk);
                hold_off_served++;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int wait_n;

        // Synchronous reset.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase one: sender idles lightly, receiver stalls most cycles.
        send_idle_pct = 16;
        recv_idle_pct <= 74;

        // Word of extreme bytes; the blank ends it with crossing allowed.
        send_beat(8'hFF, 1'b1);
        send_beat(8'h21, 1'b0);
        send_beat(8'h20, 1'b1);
        // Lone slash opens a word; the newline ends it and is counted.
        send_text("/x\n", 1'b1);
        // Comment closed by its newline: counted, no error.
        send_text("//\n", 1'b1);
        // Newline inside quotes is a token byte and leaves the line alone.
        send_text("\"\n\"", 1'b0);
        // Slash then a non-crossing newline: slash byte, token end, error.
        send_beat(CHAR_SLASH, 1'b1);
        send_beat(CHAR_NL, 1'b0);
        // Discard after the error until the end of script.
        send_beat(8'h7F, 1'b1);
        send_beat(CHAR_NUL, 1'b0);
        // End of script that may not cross: error only, line back to one.
        send_beat(CHAR_NUL, 1'b0);
        // Comment opened while crossing is not allowed.
        send_text("//", 1'b0);
        send_beat(CHAR_NUL, 1'b1);
        // End of script inside a comment, not allowed to cross.
        send_text("//", 1'b1);
        send_beat(CHAR_NUL, 1'b0);
        // End of script inside quotes.
        send_beat(CHAR_QUOTE, 1'b1);
        send_beat(8'h01, 1'b1);
        send_beat(CHAR_NUL, 1'b1);
        // Clean end of script.
        send_beat(CHAR_NUL, 1'b1);

        run_random(RANDOM_BEATS / 3);

        // Phase two: the other way round.
        send_idle_pct = 74;
        recv_idle_pct <= 16;
        run_random(RANDOM_BEATS / 3);

        // Phase three: no idling, and one long receiver hold-off while the
        // sender keeps pushing.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_off_asked <= hold_off_asked + 1;
        run_random(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));

        // Drain: wait for every predicted beat, then a little longer so any
        // stray beat shows up as unexpected.
        s_valid <= 1'b0;
        wait_n = 0;
        do begin
            @(posedge aclk);
            wait_n++;
        end while (beats_due != 0 && wait_n < 100000);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);

        if (fault_count == 0 && beats_due == 0) begin
            $display("** script_tokenizer: PASSED **");
        end else begin
            $display("** script_tokenizer: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #(20_000_000);
        $display("** script_tokenizer: FAILED **");
        $finish;
    end

endmodule
